>>> src/gn2d_pkg.sv
// shared types, constants, permutation rom and fixed-point helpers for the gradient noise block
package gn2d_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 24;
  localparam int LAT_W     = 8;
  localparam int OUT_W     = 16;
  localparam int QW        = FRAC_BITS + 6;
  localparam int PROD_W    = 2 * QW;
  localparam int OUT_SH    = FRAC_BITS + 1 - OUT_W;
  localparam int IN_DATA_W = 2 * COORD_W;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int BACK_STAGES = 9;

  typedef logic signed [QW-1:0]     q_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [FRAC_BITS-1:0]     frac_t;
  typedef logic [LAT_W-1:0]         lat_t;

  localparam q_t    Q_ONE     = QW'(1 << FRAC_BITS);
  localparam q_t    Q_TEN     = QW'(10 << FRAC_BITS);
  localparam q_t    Q_FIFTEEN = QW'(15 << FRAC_BITS);
  localparam prod_t P_HALF    = PROD_W'(1 << (FRAC_BITS - 1));
  localparam q_t    OUT_RND   = QW'(1 << (OUT_SH - 1));
  localparam q_t    OUT_MAX   = QW'((1 << OUT_W) - 1);

  // gradient picked by the low two hash bits
  typedef enum logic [1:0] {
    GRAD_XPY  = 2'd0,
    GRAD_NXPY = 2'd1,
    GRAD_XMY  = 2'd2,
    GRAD_NXMY = 2'd3
  } grad_sel_e;

  typedef struct packed {
    frac_t     xf;
    frac_t     yf;
    grad_sel_e h00;
    grad_sel_e h10;
    grad_sel_e h01;
    grad_sel_e h11;
  } corner_item_t;

  localparam lat_t PERM_ROM [256] = '{
    151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,
    140,36,103,30,69,142,8,99,37,240,21,10,23,190,6,148,
    247,120,234,75,0,26,197,62,94,252,219,203,117,35,11,32,
    57,177,33,88,237,149,56,87,174,20,125,136,171,168,68,175,
    74,165,71,134,139,48,27,166,77,146,158,231,83,111,229,122,
    60,211,133,230,220,105,92,41,55,46,245,40,244,102,143,54,
    65,25,63,161,1,216,80,73,209,76,132,187,208,89,18,169,
    200,196,135,130,116,188,159,86,164,100,109,198,173,186,3,64,
    52,217,226,250,124,123,5,202,38,147,118,126,255,82,85,212,
    207,206,59,227,47,16,58,17,182,189,28,42,223,183,170,213,
    119,248,152,2,44,154,163,70,221,153,101,155,167,43,172,9,
    129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,
    218,246,97,228,251,34,242,193,238,210,144,12,191,179,162,241,
    81,51,145,235,249,14,239,107,49,192,214,31,181,199,106,157,
    184,84,204,176,115,121,50,45,127,4,150,254,138,236,205,93,
    222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180
  };

  // product back to q format, magnitude rounded half away from zero
  function automatic q_t qround(input prod_t p);
    prod_t mag;
    prod_t r;
    mag = p[PROD_W-1] ? -p : p;
    r   = (mag + P_HALF) >> FRAC_BITS;
    r   = p[PROD_W-1] ? -r : r;
    return r[QW-1:0];
  endfunction

  function automatic q_t grad(input grad_sel_e h, input q_t dx, input q_t dy);
    q_t g;
    unique case (h)
      GRAD_XPY:  g = dx + dy;
      GRAD_NXPY: g = dy - dx;
      GRAD_XMY:  g = dx - dy;
      GRAD_NXMY: g = -dx - dy;
      default:   g = dx + dy;
    endcase
    return g;
  endfunction

endpackage

>>> src/gn2d_front.sv
// front end: takes points and hashes the four cell corners through the permutation rom
module gn2d_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [gn2d_pkg::IN_DATA_W-1:0] in_data_i,
  input  logic                      fifo_full_i,
  output logic                      push_o,
  output gn2d_pkg::corner_item_t    item_o
);
  import gn2d_pkg::*;

  logic  en;
  lat_t  xi, yi;
  frac_t xf, yf;

  logic  f1_vld_q, f1_vld_d;
  lat_t  px0_q, px0_d, px1_q, px1_d, yi_q, yi_d;
  frac_t xf1_q, xf1_d, yf1_q, yf1_d;

  logic  f2_vld_q, f2_vld_d;
  corner_item_t item_q, item_d;

  assign en         = !f2_vld_q || !fifo_full_i;
  assign in_ready_o = en;
  assign push_o     = f2_vld_q && !fifo_full_i;
  assign item_o     = item_q;

  assign xi = in_data_i[FRAC_BITS +: LAT_W];
  assign yi = in_data_i[COORD_W + FRAC_BITS +: LAT_W];
  assign xf = in_data_i[0 +: FRAC_BITS];
  assign yf = in_data_i[COORD_W +: FRAC_BITS];

  // first rom level: row hashes for both x corners
  always_comb begin
    f1_vld_d = in_valid_i;
    px0_d    = PERM_ROM[xi];
    px1_d    = PERM_ROM[lat_t'(xi + lat_t'(1))];
    yi_d     = yi;
    xf1_d    = xf;
    yf1_d    = yf;
  end

  // second rom level: corner hashes, index wraps in the lattice width
  always_comb begin
    lat_t h00, h01, h10, h11;
    h00 = PERM_ROM[lat_t'(px0_q + yi_q)];
    h01 = PERM_ROM[lat_t'(px0_q + yi_q + lat_t'(1))];
    h10 = PERM_ROM[lat_t'(px1_q + yi_q)];
    h11 = PERM_ROM[lat_t'(px1_q + yi_q + lat_t'(1))];
    f2_vld_d    = f1_vld_q;
    item_d.xf   = xf1_q;
    item_d.yf   = yf1_q;
    item_d.h00  = grad_sel_e'(h00[1:0]);
    item_d.h01  = grad_sel_e'(h01[1:0]);
    item_d.h10  = grad_sel_e'(h10[1:0]);
    item_d.h11  = grad_sel_e'(h11[1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_vld_q <= 1'b0;
      f2_vld_q <= 1'b0;
    end else if (en) begin
      f1_vld_q <= f1_vld_d;
      f2_vld_q <= f2_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      px0_q  <= px0_d;
      px1_q  <= px1_d;
      yi_q   <= yi_d;
      xf1_q  <= xf1_d;
      yf1_q  <= yf1_d;
      item_q <= item_d;
    end
  end

endmodule

>>> src/gn2d_fifo.sv
// short queue of hashed corner items between the front and back ends
module gn2d_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  gn2d_pkg::corner_item_t data_i,
  input  logic                   pop_i,
  output gn2d_pkg::corner_item_t data_o,
  output logic                   full_o,
  output logic                   empty_o
);
  import gn2d_pkg::*;

  corner_item_t mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + FIFO_AW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (FIFO_AW+1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (FIFO_AW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> src/gn2d_fade.sv
// quintic fade 6t^5-15t^4+10t^3 as a four-register pipeline
module gn2d_fade (
  input  logic            clk_i,
  input  logic            en_i,
  input  gn2d_pkg::frac_t t_i,
  output gn2d_pkg::q_t    f_o
);
  import gn2d_pkg::*;

  q_t    tq, lin;
  prod_t sq_q, sq_d, lp_q, lp_d;
  frac_t ta_q;
  prod_t p3_q, p3_d;
  q_t    inner_q, inner_d;
  prod_t p4_q, p4_d;
  q_t    f_q, f_d;

  // t*(6t-15) and t*t
  always_comb begin
    tq   = q_t'(t_i);
    lin  = (tq <<< 2) + (tq <<< 1) - Q_FIFTEEN;
    lp_d = prod_t'(tq) * prod_t'(lin);
    sq_d = prod_t'(tq) * prod_t'(tq);
  end

  // inner term and t^3
  always_comb begin
    q_t t2;
    t2      = qround(sq_q);
    inner_d = qround(lp_q) + Q_TEN;
    p3_d    = prod_t'(t2) * prod_t'(q_t'(ta_q));
  end

  // inner term sits in the same stage as t^3
  always_comb begin
    q_t t3;
    t3   = qround(p3_q);
    p4_d = prod_t'(t3) * prod_t'(inner_q);
  end

  always_comb begin
    f_d = qround(p4_q);
    if (f_d < 0) begin
      f_d = '0;
    end else if (f_d > Q_ONE) begin
      f_d = Q_ONE;
    end
  end

  assign f_o = f_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q    <= sq_d;
      lp_q    <= lp_d;
      ta_q    <= t_i;
      p3_q    <= p3_d;
      inner_q <= inner_d;
      p4_q    <= p4_d;
      f_q     <= f_d;
    end
  end

endmodule

>>> src/gn2d_back.sv
// back end: gradients, fades, bilinear blend and output mapping, one item per cycle while the output is not stalled
module gn2d_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   empty_i,
  input  gn2d_pkg::corner_item_t item_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [gn2d_pkg::OUT_W-1:0] noise_o
);
  import gn2d_pkg::*;

  logic en;
  logic [BACK_STAGES-1:0] vld_q, vld_d;
  q_t u, v;

  // stage 0: corner gradients
  q_t g00_q, g10_q, g01_q, g11_q, g00_d, g10_d, g01_d, g11_d;
  // stage 1: row bases and spans, then two delay stages to meet the fades
  q_t a0_q [3], a1_q [3], d0_q [3], d1_q [3];
  // stage 4: row products
  prod_t pr0_q, pr1_q, pr0_d, pr1_d;
  q_t a0_4_q, a1_4_q, v4_q;
  // stage 5: rows
  q_t row0_q, row1_q, row0_d, row1_d, v5_q;
  // stage 6: column product
  prod_t pn_q, pn_d;
  q_t row0_6_q;
  // stage 7: noise, stage 8: output word
  q_t n_q, n_d;
  logic [OUT_W-1:0] out_q, out_d;

  assign en          = !vld_q[BACK_STAGES-1] || out_ready_i;
  assign pop_o       = en && !empty_i;
  assign out_valid_o = vld_q[BACK_STAGES-1];
  assign noise_o     = out_q;

  assign vld_d = {vld_q[BACK_STAGES-2:0], !empty_i};

  gn2d_fade u_fade_x (
    .clk_i (clk_i),
    .en_i  (en),
    .t_i   (item_i.xf),
    .f_o   (u)
  );

  gn2d_fade u_fade_y (
    .clk_i (clk_i),
    .en_i  (en),
    .t_i   (item_i.yf),
    .f_o   (v)
  );

  always_comb begin
    q_t dx0, dy0, dx1, dy1;
    dx0   = q_t'(item_i.xf);
    dy0   = q_t'(item_i.yf);
    dx1   = dx0 - Q_ONE;
    dy1   = dy0 - Q_ONE;
    g00_d = grad(item_i.h00, dx0, dy0);
    g10_d = grad(item_i.h10, dx1, dy0);
    g01_d = grad(item_i.h01, dx0, dy1);
    g11_d = grad(item_i.h11, dx1, dy1);
  end

  // fade outputs line up with the last span delay stage
  always_comb begin
    pr0_d = prod_t'(u) * prod_t'(d0_q[2]);
    pr1_d = prod_t'(u) * prod_t'(d1_q[2]);
  end

  always_comb begin
    row0_d = a0_4_q + qround(pr0_q);
    row1_d = a1_4_q + qround(pr1_q);
    pn_d   = prod_t'(v5_q) * prod_t'(row1_q - row0_q);
    n_d    = row0_6_q + qround(pn_q);
  end

  // (n+1)/2 with rounding, clamped to the output range
  always_comb begin
    q_t val;
    q_t r;
    val = n_q + Q_ONE;
    if (val < 0) begin
      val = '0;
    end
    r = (val + OUT_RND) >>> OUT_SH;
    if (r > OUT_MAX) begin
      r = OUT_MAX;
    end
    out_d = r[OUT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g00_q    <= g00_d;
      g10_q    <= g10_d;
      g01_q    <= g01_d;
      g11_q    <= g11_d;
      a0_q[0]  <= g00_q;
      a1_q[0]  <= g01_q;
      d0_q[0]  <= g10_q - g00_q;
      d1_q[0]  <= g11_q - g01_q;
      a0_q[1]  <= a0_q[0];
      a1_q[1]  <= a1_q[0];
      d0_q[1]  <= d0_q[0];
      d1_q[1]  <= d1_q[0];
      a0_q[2]  <= a0_q[1];
      a1_q[2]  <= a1_q[1];
      d0_q[2]  <= d0_q[1];
      d1_q[2]  <= d1_q[1];
      pr0_q    <= pr0_d;
      pr1_q    <= pr1_d;
      a0_4_q   <= a0_q[2];
      a1_4_q   <= a1_q[2];
      v4_q     <= v;
      row0_q   <= row0_d;
      row1_q   <= row1_d;
      v5_q     <= v4_q;
      pn_q     <= pn_d;
      row0_6_q <= row0_q;
      n_q      <= n_d;
      out_q    <= out_d;
    end
  end

endmodule

>>> src/gradient_noise_2d_top.sv
// top level of the 2d gradient noise block
//
//  port group   dir  tdata fields (low bit first)
//  s_axis       in   coord_x[23:0], coord_y[47:24]
//  m_axis       out  noise_value[15:0]
//
// one point per cycle sustained when nothing stalls; the front hashes through its rom
// levels, then the back runs the fade and blend multiplier chain.
// reset clears all valid flags and the queue; no table needs clearing.
// a 4-word queue splits front and back: output stalls hold the back pipeline,
// and the input is stalled only once the queue fills.
module gradient_noise_2d_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // coord_x[23:0], coord_y[47:24]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // noise_value[15:0]
);
  import gn2d_pkg::*;

  logic         push, pop, full, empty;
  corner_item_t front_item, head_item;

  gn2d_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i),
    .fifo_full_i (full),
    .push_o      (push),
    .item_o      (front_item)
  );

  gn2d_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_item),
    .pop_i   (pop),
    .data_o  (head_item),
    .full_o  (full),
    .empty_o (empty)
  );

  gn2d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .item_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .noise_o     (m_axis_tdata_o)
  );

endmodule

>>> test/gradient_noise_2d_top_test.sv
// self-checking testbench for the 2d gradient noise block with its own noise predictor
module gradient_noise_2d_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gn2d_pkg::*;

  localparam int     FRAC       = 16;
  localparam longint Q_ONE      = longint'(1) << FRAC;
  localparam longint Q_HALF     = longint'(1) << (FRAC - 1);
  localparam int     RAND_ITEMS = 1130;
  localparam int     CALM_FROM  = 900;
  localparam int     CALM_TO    = 1250;
  localparam int     HOLD_AT    = 350;
  localparam int     HOLD_LEN   = 300;
  localparam int     TAIL_WAIT  = 40;
  localparam int     CYCLE_CAP  = 60000;

  localparam logic [7:0] LATTICE_PERM [256] = '{
    151,160,137,91,90,15,131,13,201,95,96,53,194,233,7,225,
    140,36,103,30,69,142,8,99,37,240,21,10,23,190,6,148,
    247,120,234,75,0,26,197,62,94,252,219,203,117,35,11,32,
    57,177,33,88,237,149,56,87,174,20,125,136,171,168,68,175,
    74,165,71,134,139,48,27,166,77,146,158,231,83,111,229,122,
    60,211,133,230,220,105,92,41,55,46,245,40,244,102,143,54,
    65,25,63,161,1,216,80,73,209,76,132,187,208,89,18,169,
    200,196,135,130,116,188,159,86,164,100,109,198,173,186,3,64,
    52,217,226,250,124,123,5,202,38,147,118,126,255,82,85,212,
    207,206,59,227,47,16,58,17,182,189,28,42,223,183,170,213,
    119,248,152,2,44,154,163,70,221,153,101,155,167,43,172,9,
    129,22,39,253,19,98,108,110,79,113,224,232,178,185,112,104,
    218,246,97,228,251,34,242,193,238,210,144,12,191,179,162,241,
    81,51,145,235,249,14,239,107,49,192,214,31,181,199,106,157,
    184,84,204,176,115,121,50,45,127,4,150,254,138,236,205,93,
    222,114,67,29,24,72,243,141,128,195,78,66,215,61,156,180
  };

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_valid = 1'b0;
  logic [47:0] s_tdata = '0;   // coord_x[23:0], coord_y[47:24]
  logic        s_ready;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [15:0] m_tdata;        // noise_value[15:0]

  logic [47:0] point_backlog [$];
  logic [15:0] noise_due [$];
  int unsigned cyc = 0;
  int unsigned hold_left = 0;
  int unsigned mismatch_count = 0;
  logic        calm;

  gradient_noise_2d_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  assign calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  // append a point at the tail of the backlog
  function automatic void queue_point(input logic [47:0] w);
    point_backlog.insert(point_backlog.size(), w);
  endfunction

  // fixed-point product, magnitude rounded half away from zero
  function automatic longint q_mul(input longint a, input longint b);
    longint p;
    longint mag;
    longint r;
    p   = a * b;
    mag = (p < 0) ? -p : p;
    r   = (mag + Q_HALF) >>> FRAC;
    return (p < 0) ? -r : r;
  endfunction

  // quintic smoothstep 6t^5-15t^4+10t^3
  function automatic longint fade_q(input longint t);
    longint inner;
    longint t2;
    longint t3;
    longint f;
    inner = q_mul(t, 6 * t - 15 * Q_ONE) + 10 * Q_ONE;
    t2    = q_mul(t, t);
    t3    = q_mul(t2, t);
    f     = q_mul(t3, inner);
    if (f < 0) f = 0;
    if (f > Q_ONE) f = Q_ONE;
    return f;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint t);
    return a + q_mul(t, b - a);
  endfunction

  function automatic longint corner_dot(input logic [7:0] h, input longint dx,
                                        input longint dy);
    longint g;
    case (grad_sel_e'(h[1:0]))
      GRAD_XPY:  g = dx + dy;
      GRAD_NXPY: g = dy - dx;
      GRAD_XMY:  g = dx - dy;
      GRAD_NXMY: g = -dx - dy;
      default:   g = 0;
    endcase
    return g;
  endfunction

  function automatic logic [7:0] perm_at(input logic [7:0] idx);
    return LATTICE_PERM[idx];
  endfunction

  function automatic logic [15:0] noise_of_point(input logic [47:0] w);
    logic [7:0] xi;
    logic [7:0] yi;
    logic [7:0] px0;
    logic [7:0] px1;
    longint     xf;
    longint     yf;
    longint     u;
    longint     v;
    longint     row0;
    longint     row1;
    longint     n;
    longint     r;
    xi   = w[23:16];
    yi   = w[47:40];
    xf   = w[15:0];
    yf   = w[39:24];
    u    = fade_q(xf);
    v    = fade_q(yf);
    px0  = perm_at(xi);
    px1  = perm_at(xi + 8'd1);
    row0 = blend(corner_dot(perm_at(px0 + yi), xf, yf),
                 corner_dot(perm_at(px1 + yi), xf - Q_ONE, yf), u);
    row1 = blend(corner_dot(perm_at(px0 + yi + 8'd1), xf, yf - Q_ONE),
                 corner_dot(perm_at(px1 + yi + 8'd1), xf - Q_ONE, yf - Q_ONE), u);
    n    = blend(row0, row1, v) + Q_ONE;
    if (n < 0) n = 0;
    r = (n + 1) >>> 1;
    if (r > 65535) r = 65535;
    return r[15:0];
  endfunction

  // fill the backlog: directed points first, then random ones
  initial begin
    logic [47:0] p;
    logic [15:0] fr [5];
    bit          got_hi;
    bit          got_lo;
    int          kind;
    fr = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFE, 16'hFFFF};
    queue_point({24'h000000, 24'h000000});
    queue_point({24'hFFFFFF, 24'hFFFFFF});
    queue_point({24'h000000, 24'hFFFFFF});
    queue_point({24'hFFFFFF, 24'h000000});
    queue_point({24'h008000, 24'h008000});
    queue_point({24'hFF8000, 24'hFF8000});
    queue_point({24'h000001, 24'h00FFFF});
    queue_point({24'h00FFFF, 24'h000001});
    queue_point({24'h7F4000, 24'hFF0000});
    queue_point({24'h80C000, 24'hFFFFFF});
    queue_point({24'h555555, 24'hAAAAAA});
    queue_point({24'hAAAAAA, 24'h555555});
    queue_point({24'h654321, 24'h123456});
    // a row of cells at quarter offsets walks through the gradient choices
    for (int i = 0; i < 8; i++) begin
      queue_point({24'h004000, 8'(i), 16'h4000});
    end
    // cell centers where the sum reaches +1 and -1, so the output pins at its ends
    got_hi = 1'b0;
    got_lo = 1'b0;
    for (int cx = 0; cx < 256 && !(got_hi && got_lo); cx++) begin
      for (int cy = 0; cy < 256 && !(got_hi && got_lo); cy++) begin
        p = {8'(cy), 16'h8000, 8'(cx), 16'h8000};
        if (!got_hi && noise_of_point(p) == 16'hFFFF) begin
          queue_point(p);
          got_hi = 1'b1;
        end else if (!got_lo && noise_of_point(p) == 16'h0000) begin
          queue_point(p);
          got_lo = 1'b1;
        end
      end
    end
    for (int i = 0; i < RAND_ITEMS; i++) begin
      kind = $urandom_range(0, 99);
      p = {16'($urandom), $urandom};
      if (kind < 15) begin
        p[15:0]  = fr[$urandom_range(0, 4)];
        p[39:24] = fr[$urandom_range(0, 4)];
      end else if (kind < 25) begin
        p[23:16] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        p[47:40] = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      end
      queue_point(p);
    end
  end

  // sender
  always @(posedge clk_i) begin
    if (!rst_n) begin
      s_valid <= 1'b0;
    end else if (!s_valid || s_ready) begin
      if (s_valid) begin
        noise_due.insert(noise_due.size(), noise_of_point(s_tdata));
      end
      if (point_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= 31)) begin
        s_valid <= 1'b1;
        s_tdata <= point_backlog.pop_front();
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off so the queue fills and input stalls
  always @(posedge clk_i) begin
    if (!rst_n) begin
      m_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else if (cyc == HOLD_AT) begin
      hold_left <= HOLD_LEN;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= calm || ($urandom_range(0, 99) >= 31);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    logic [15:0] want;
    if (rst_n && m_valid && m_ready) begin
      if (noise_due.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 10) begin
          $display("unexpected word: noise_value %h", m_tdata);
        end
      end else begin
        want = noise_due.pop_front();
        if (m_tdata !== want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) begin
            $display("noise_value mismatch: expected %h actual %h", want, m_tdata);
          end
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    while (point_backlog.size() != 0 || s_valid || noise_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("gradient_noise_2d_top_test: clean");
    end else begin
      $display("gradient_noise_2d_top_test: errors");
    end
    $finish;
  end

  initial begin
    while (cyc < CYCLE_CAP) @(posedge clk_i);
    $display("gradient_noise_2d_top_test: errors");
    $finish;
  end

endmodule

>>> sim.f
src/gn2d_pkg.sv
src/gn2d_front.sv
src/gn2d_fifo.sv
src/gn2d_fade.sv
src/gn2d_back.sv
src/gradient_noise_2d_top.sv
test/gradient_noise_2d_top_test.sv
